// ===== rtl/ptpa_pkg.sv =====
`default_nettype none

package ptpa_pkg;

  localparam int PaletteDepthDefault = 256;

  localparam int CfgIdxW  = 1;
  localparam int CfgDataW = 9;

  localparam logic [CfgIdxW-1:0] CFG_PALETTE_COUNT     = 1'd0;
  localparam logic [CfgIdxW-1:0] CFG_TRANSPARENT_INDEX = 1'd1;

  localparam logic [8:0] PaletteCountReset     = 9'd256;
  localparam logic [8:0] TransparentIndexReset = 9'h1FF;

  typedef enum logic [0:0] {
    OP_LOAD  = 1'b0,
    OP_PIXEL = 1'b1
  } opcode_e;

  typedef struct packed {
    opcode_e    opcode;
    logic [7:0] color_index;
    logic [7:0] entry_alpha;
    logic [7:0] entry_red;
    logic [7:0] entry_green;
    logic [7:0] entry_blue;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_alpha;
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
  } out_item_t;

  typedef struct packed {
    logic [7:0] alpha;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } palette_entry_t;

endpackage

`default_nettype wire

// ===== rtl/palette_to_premultiplied_argb_unit.sv =====
// A pixel transfer passes the palette read register, then the premultiply into the
// result register, before its result is valid.
// Throughput: one item per cycle while out_stall_i does not stall the pipeline;
// the palette RAM has one write and one read port. Palette loads produce no result.
// Reset clears the pipeline valids and sets palette_count to 256 and
// transparent_index to -1; the palette RAM is not cleared.
`default_nettype none

module palette_to_premultiplied_argb_unit #(
  parameter int PALETTE_DEPTH = ptpa_pkg::PaletteDepthDefault
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_valid_i,
  output logic                                  in_stall_o,
  input  wire ptpa_pkg::in_item_t               in_item_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_stall_i,
  output ptpa_pkg::out_item_t                   out_item_o,
  input  wire logic                             cfg_we_i,
  input  wire logic [ptpa_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  wire logic [ptpa_pkg::CfgDataW-1:0]    cfg_data_i
);

  localparam int         AddrW      = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
  localparam logic [8:0] DepthLimit = 9'(PALETTE_DEPTH);

  ptpa_pkg::palette_entry_t mem_q [PALETTE_DEPTH];
  ptpa_pkg::palette_entry_t rd_q;
  ptpa_pkg::palette_entry_t wr_entry;

  logic [8:0]       count_q;
  logic [8:0]       transp_q;
  logic [8:0]       idx9;
  logic [AddrW-1:0] addr;
  logic             in_ok, in_range, is_pixel, is_transp, zero_d;
  logic             s1_valid_q, s1_valid_d, s1_zero_q, s1_ready;
  logic             core_stall;

  assign idx9      = {1'b0, in_item_i.color_index};
  assign addr      = in_item_i.color_index[AddrW-1:0];
  assign in_ok     = in_valid_i && !in_stall_o;
  assign in_range  = idx9 < DepthLimit;
  assign is_pixel  = in_item_i.opcode == ptpa_pkg::OP_PIXEL;
  assign is_transp = !transp_q[8] && (transp_q[7:0] == in_item_i.color_index);
  assign zero_d    = !in_range || (idx9 >= count_q) || is_transp;

  assign wr_entry.alpha = in_item_i.entry_alpha;
  assign wr_entry.red   = in_item_i.entry_red;
  assign wr_entry.green = in_item_i.entry_green;
  assign wr_entry.blue  = in_item_i.entry_blue;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= ptpa_pkg::PaletteCountReset;
      transp_q <= ptpa_pkg::TransparentIndexReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        ptpa_pkg::CFG_PALETTE_COUNT:     count_q  <= cfg_data_i;
        ptpa_pkg::CFG_TRANSPARENT_INDEX: transp_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // palette RAM
  always_ff @(posedge clk_i) begin
    if (in_ok && !is_pixel && in_range) begin
      mem_q[addr] <= wr_entry;
    end
    if (in_ok && is_pixel && in_range) begin
      rd_q <= mem_q[addr];
    end
    if (in_ok) begin
      s1_zero_q <= zero_d;
    end
  end

  assign s1_ready   = !s1_valid_q || !core_stall;
  assign in_stall_o = !s1_ready;
  assign s1_valid_d = s1_ready ? (in_ok && is_pixel) : s1_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  ptpa_premul u_premul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s1_valid_q),
    .stall_o (core_stall),
    .entry_i (rd_q),
    .zero_i  (s1_zero_q),
    .valid_o (out_valid_o),
    .stall_i (out_stall_i),
    .item_o  (out_item_o)
  );

endmodule

`default_nettype wire

// ===== rtl/ptpa_premul.sv =====
`default_nettype none

module ptpa_premul (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     valid_i,
  output logic                          stall_o,
  input  wire ptpa_pkg::palette_entry_t entry_i,
  input  wire logic                     zero_i,
  output logic                          valid_o,
  input  wire logic                     stall_i,
  output ptpa_pkg::out_item_t           item_o
);

  // floor(x / 255) for x <= 255*255
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [15:0] s;
    s = x + {8'd0, x[15:8]} + 16'd1;
    return s[15:8];
  endfunction

  logic                valid_q, valid_d;
  logic                ready;
  logic [7:0]          a_eff;
  logic [15:0]         prod_red, prod_green, prod_blue;
  ptpa_pkg::out_item_t item_q, item_d;

  assign ready   = !valid_q || !stall_i;
  assign stall_o = !ready;

  assign a_eff = zero_i ? 8'd0 : entry_i.alpha;

  assign prod_red   = {8'd0, a_eff} * {8'd0, entry_i.red};
  assign prod_green = {8'd0, a_eff} * {8'd0, entry_i.green};
  assign prod_blue  = {8'd0, a_eff} * {8'd0, entry_i.blue};

  assign item_d.out_alpha = a_eff;
  assign item_d.out_red   = div255(prod_red);
  assign item_d.out_green = div255(prod_green);
  assign item_d.out_blue  = div255(prod_blue);

  assign valid_d = ready ? valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready) begin
      item_q <= item_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

`default_nettype wire
